/* sv/assert_macros.svh */
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define URS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define URS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/urs_pkg.sv */
// ----------------------------------------------------------------------------
// urs_pkg
// Types, widths and reset values shared by the ultrasonic range sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urs_pkg;

	// field widths
	localparam int TRIG_W   = 16;
	localparam int PERIOD_W = 22;
	localparam int SCALE_W  = 10;
	localparam int TICKS_W  = 16;
	localparam int DIST_W   = 26;
	localparam int CFG_DATA_W = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 48;

	localparam int ECHO_COUNT_BITS_DEF = 16;

	// register reset values
	localparam logic [TRIG_W-1:0]   TRIG_TICKS_RST = TRIG_W'(1000);
	localparam logic [PERIOD_W-1:0] PERIOD_RST     = PERIOD_W'(300000);
	localparam logic [SCALE_W-1:0]  SCALE_RST      = SCALE_W'(170);
	localparam logic [TICKS_W-1:0]  TICKS_MAX      = '1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TRIG  = 2'd1,
		PH_RISE  = 2'd2,
		PH_COUNT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_ECHO_HI  = 2'd1,
		ERR_EARLY    = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRIGGER_TICKS = 2'd0,
		CFG_PERIOD_TICKS  = 2'd1,
		CFG_SCALE         = 2'd2,
		CFG_ENABLE        = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [TRIG_W-1:0]   trigger_ticks;
		logic [PERIOD_W-1:0] period_ticks;
		logic [SCALE_W-1:0]  scale_um_per_tick;
		logic                enable;
	} cfg_t;

	// sequencer state apart from the echo counter
	typedef struct packed {
		phase_t              phase;
		logic [PERIOD_W-1:0] period_count;
		logic [TRIG_W-1:0]   trigger_count;
		logic                echo_prev;
	} st_t;

	typedef struct packed {
		logic [DIST_W-1:0]  distance_um;
		logic [TICKS_W-1:0] echo_ticks;
		err_t               error_code;
		logic               done_res;
		logic               trigger_level;
	} res_t;

endpackage

/* sv/urs_step.sv */
// ----------------------------------------------------------------------------
// urs_step
// Next-state and result logic for one time-base tick of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urs_step
	import urs_pkg::*;
#(
	parameter int ECHO_COUNT_BITS = ECHO_COUNT_BITS_DEF
) (
	input  cfg_t                       cfg,
	input  st_t                        st,
	input  logic [ECHO_COUNT_BITS-1:0] echo_count,
	input  logic                       echo_level,
	output st_t                        st_nxt,
	output logic [ECHO_COUNT_BITS-1:0] echo_count_nxt,
	output res_t                       res
);

	logic                  fell;
	logic                  start;
	logic                  trig_end;
	logic                  cnt_full;
	logic [PERIOD_W-1:0]   per;
	logic [PERIOD_W:0]     pc_inc;
	logic [31:0]           ec_wide;
	logic [TICKS_W-1:0]    ticks_sat;
	logic [DIST_W-1:0]     scaled_um;

	assign fell     = st.echo_prev & ~echo_level;
	assign start    = (st.period_count == '0);
	assign trig_end = (st.trigger_count >= cfg.trigger_ticks);
	assign cnt_full = (echo_count == '1);

	// zero period behaves as one
	assign per    = (cfg.period_ticks == '0) ? PERIOD_W'(1) : cfg.period_ticks;
	assign pc_inc = {1'b0, st.period_count} + (PERIOD_W+1)'(1);

	// saturate the count to the report width, then scale
	assign ec_wide   = 32'(echo_count);
	assign ticks_sat = (ec_wide > 32'(TICKS_MAX)) ? TICKS_MAX : ec_wide[TICKS_W-1:0];
	assign scaled_um = DIST_W'(ticks_sat) * DIST_W'(cfg.scale_um_per_tick);

	// next state
	always_comb begin
		st_nxt         = st;
		echo_count_nxt = echo_count;
		st_nxt.echo_prev = echo_level;
		if (!cfg.enable) begin
			st_nxt.phase        = PH_IDLE;
			st_nxt.period_count = '0;
		end else begin
			if (start) begin
				st_nxt.phase         = PH_TRIG;
				st_nxt.trigger_count = TRIG_W'(1);
				echo_count_nxt       = '0;
			end else begin
				unique case (st.phase)
					PH_TRIG: begin
						if (fell || (trig_end && echo_level)) begin
							st_nxt.phase = PH_IDLE;
						end else if (trig_end) begin
							st_nxt.phase = PH_RISE;
						end else begin
							st_nxt.trigger_count = st.trigger_count + TRIG_W'(1);
						end
					end
					PH_RISE: begin
						if (fell) begin
							st_nxt.phase = PH_IDLE;
						end else if (echo_level) begin
							echo_count_nxt = ECHO_COUNT_BITS'(1);
							st_nxt.phase   = PH_COUNT;
						end
					end
					PH_COUNT: begin
						if (!echo_level || cnt_full) begin
							st_nxt.phase = PH_IDLE;
						end else begin
							echo_count_nxt = echo_count + ECHO_COUNT_BITS'(1);
						end
					end
					default: begin
						st_nxt.phase = st.phase;
					end
				endcase
			end
			// period counter wraps at the period length
			st_nxt.period_count = (pc_inc >= {1'b0, per}) ? '0 : pc_inc[PERIOD_W-1:0];
		end
	end

	// result word
	always_comb begin
		res = '0;
		if (cfg.enable) begin
			if (start) begin
				res.trigger_level = 1'b1;
			end else begin
				unique case (st.phase)
					PH_TRIG: begin
						if (fell) begin
							res.done_res   = 1'b1;
							res.error_code = ERR_EARLY;
						end else if (trig_end) begin
							if (echo_level) begin
								res.done_res   = 1'b1;
								res.error_code = ERR_ECHO_HI;
							end
						end else begin
							res.trigger_level = 1'b1;
						end
					end
					PH_RISE: begin
						if (fell) begin
							res.done_res   = 1'b1;
							res.error_code = ERR_EARLY;
						end
					end
					PH_COUNT: begin
						if (!echo_level) begin
							res.done_res    = 1'b1;
							res.error_code  = ERR_NONE;
							res.echo_ticks  = ticks_sat;
							res.distance_um = scaled_um;
						end else if (cnt_full) begin
							res.done_res   = 1'b1;
							res.error_code = ERR_OVERFLOW;
							res.echo_ticks = ticks_sat;
						end
					end
					default: begin
						res.done_res = 1'b0;
					end
				endcase
			end
		end
	end

endmodule

/* sv/ultrasonic_range_sequencer_core.sv */
// ----------------------------------------------------------------------------
// ultrasonic_range_sequencer_core: word in to result word out via input and output registers
// throughput one word per cycle unless m_tready stalls, set by the single step stage and output register
// reset: asynchronous, registers at their reset values, sequencer idle, no data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ultrasonic_range_sequencer_core
	import urs_pkg::*;
#(
	parameter int ECHO_COUNT_BITS = ECHO_COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// tdata: [0] echo_level
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// tdata: [0] trigger_level, [1] done_res, [3:2] error_code,
	//        [19:4] echo_ticks, [45:20] distance_um
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                       cfg_q;
	st_t                        st_q;
	st_t                        st_nxt;
	logic [ECHO_COUNT_BITS-1:0] echo_count_q;
	logic [ECHO_COUNT_BITS-1:0] echo_count_nxt;
	logic                       valid_s1;
	logic                       echo_s1;
	logic                       m_tvalid_q;
	res_t                       res_q;
	res_t                       res;
	logic                       out_free;
	logic                       step;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks     <= TRIG_TICKS_RST;
			cfg_q.period_ticks      <= PERIOD_RST;
			cfg_q.scale_um_per_tick <= SCALE_RST;
			cfg_q.enable            <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TRIGGER_TICKS: cfg_q.trigger_ticks     <= cfg_data[TRIG_W-1:0];
				CFG_PERIOD_TICKS:  cfg_q.period_ticks      <= cfg_data[PERIOD_W-1:0];
				CFG_SCALE:         cfg_q.scale_um_per_tick <= cfg_data[SCALE_W-1:0];
				CFG_ENABLE:        cfg_q.enable            <= cfg_data[0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// handshake: the output register frees as soon as its word is taken
	assign out_free = !m_tvalid_q || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			echo_s1 <= s_tdata[0];
		end
	end

	urs_step #(
		.ECHO_COUNT_BITS(ECHO_COUNT_BITS)
	) u_step (
		.cfg            (cfg_q),
		.st             (st_q),
		.echo_count     (echo_count_q),
		.echo_level     (echo_s1),
		.st_nxt         (st_nxt),
		.echo_count_nxt (echo_count_nxt),
		.res            (res)
	);

	// sequencer state advances once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase         <= PH_IDLE;
			st_q.period_count  <= '0;
			st_q.trigger_count <= '0;
			st_q.echo_prev     <= 1'b0;
			echo_count_q       <= '0;
		end else if (step) begin
			st_q         <= st_nxt;
			echo_count_q <= echo_count_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(res_q);

	// checks
	`URS_ASSERT_NOW(a_quiet_fields, m_tvalid_q && !res_q.done_res,
		res_q.error_code == ERR_NONE && res_q.echo_ticks == '0 && res_q.distance_um == '0,
		"result fields set without a finished measurement")
	`URS_ASSERT_NOW(a_err_no_dist, m_tvalid_q && res_q.done_res && res_q.error_code != ERR_NONE,
		res_q.distance_um == '0, "distance reported on a failed measurement")
	`URS_ASSERT_NEXT(a_disabled_idle, step && !cfg_q.enable,
		st_q.phase == PH_IDLE && st_q.period_count == '0, "sequencer not held idle while disabled")
	`URS_ASSERT_NEXT(a_done_goes_idle, step && res.done_res,
		st_q.phase == PH_IDLE, "sequencer still busy after reporting")

endmodule
